[design/response_frame_sync_core_macros.svh]
// ----------------------------------------------------------------------------
// Response frame sync assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef RESPONSE_FRAME_SYNC_CORE_MACROS_SVH
`define RESPONSE_FRAME_SYNC_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rfs assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rfs assertion failed");

`endif

[design/rfs_pkg.sv]
// ----------------------------------------------------------------------------
// Response frame sync package
// Window geometry, frame constants, mode and status codes, command table.
// ----------------------------------------------------------------------------
package rfs_pkg;

    localparam int WINDOW_DEPTH = 13;

    // Window positions of the first byte of a 13-byte and a 9-byte frame.
    localparam int LONG_START  = WINDOW_DEPTH - 13;
    localparam int SHORT_START = WINDOW_DEPTH - 9;

    typedef logic [WINDOW_DEPTH-1:0][7:0] window_t;

    localparam logic [7:0] SYNC_BYTE0 = 8'h55;
    localparam logic [7:0] SYNC_BYTE1 = 8'hAA;
    localparam logic [7:0] SYNC_BYTE2 = 8'h01;

    localparam logic [3:0] LEN_NONE  = 4'd0;
    localparam logic [3:0] LEN_SHORT = 4'd9;
    localparam logic [3:0] LEN_LONG  = 4'd13;
    localparam logic [3:0] SEEN_MAX  = 4'd15;

    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    localparam logic [2:0] ST_SEARCH  = 3'd0;
    localparam logic [2:0] ST_MATCH   = 3'd1;
    localparam logic [2:0] ST_RAW     = 3'd2;
    localparam logic [2:0] ST_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_IDLE    = 3'd4;

    localparam logic [0:0] REG_EXPECTED_COMMAND = 1'b0;
    localparam logic [0:0] REG_TIMEOUT_MS       = 1'b1;

    typedef struct packed {
        logic        hit;
        logic [31:0] first_value;
        logic [31:0] second_value;
    } match_t;

    function automatic logic [3:0] frame_len(input logic [7:0] cmd);
        logic [3:0] len;
        case (cmd)
            8'h0B, 8'h0D, 8'h11: begin
                len = LEN_LONG;
            end
            8'h03, 8'h0F, 8'h17, 8'h19, 8'h1D: begin
                len = LEN_SHORT;
            end
            default: begin
                len = LEN_NONE;
            end
        endcase
        return len;
    endfunction

endpackage

[design/rfs_cell.sv]
// ----------------------------------------------------------------------------
// Response frame sync window cell
// One byte of the receive window; loads its input byte on a shift, clears on clear (clear wins).
// ----------------------------------------------------------------------------
module rfs_cell (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       clear,
    input  logic       shift,
    input  logic [7:0] din,
    output logic [7:0] q
);
    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb begin
        byte_next = byte_reg;
        if (clear) begin
            byte_next = 8'h00;
        end else if (shift) begin
            byte_next = din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= 8'h00;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign q = byte_reg;

endmodule

[design/rfs_matcher.sv]
// ----------------------------------------------------------------------------
// Response frame sync matcher
// Checks the newest bytes of the shifted window for a framed reply.
// ----------------------------------------------------------------------------
module rfs_matcher (
    input  rfs_pkg::window_t window,
    input  logic [7:0]       command,
    input  logic [3:0]       frame_len,
    input  logic [3:0]       count,
    output rfs_pkg::match_t  result
);
    import rfs_pkg::*;

    logic [7:0] pair_sum [6];
    logic [7:0] sum_short;
    logic [7:0] sum_long;
    logic       head_short;
    logic       head_long;
    logic       ok_short;
    logic       ok_long;

    // The long frame's checksum covers the short frame's bytes plus four more.
    // Bytes are added in pairs first so that the adder tree stays shallow.
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            pair_sum[i] = window[LONG_START + 2*i] + window[LONG_START + 2*i + 1];
        end
        sum_short = (pair_sum[2] + pair_sum[3]) + (pair_sum[4] + pair_sum[5]);
        sum_long  = sum_short + (pair_sum[0] + pair_sum[1]);
    end

    assign head_short = (window[SHORT_START] == SYNC_BYTE0)
                     && (window[SHORT_START + 1] == SYNC_BYTE1)
                     && (window[SHORT_START + 2] == SYNC_BYTE2)
                     && (window[SHORT_START + 3] == command);
    assign head_long  = (window[LONG_START] == SYNC_BYTE0)
                     && (window[LONG_START + 1] == SYNC_BYTE1)
                     && (window[LONG_START + 2] == SYNC_BYTE2)
                     && (window[LONG_START + 3] == command);

    assign ok_short = (frame_len == LEN_SHORT) && (count >= LEN_SHORT) && head_short
                   && (sum_short == window[WINDOW_DEPTH-1]);
    assign ok_long  = (frame_len == LEN_LONG) && (count >= LEN_LONG) && head_long
                   && (sum_long == window[WINDOW_DEPTH-1]);

    always_comb begin
        result.hit          = ok_short || ok_long;
        result.first_value  = 32'h0;
        result.second_value = 32'h0;
        if (ok_long) begin
            result.first_value  = window[LONG_START + 4 +: 4];
            result.second_value = window[LONG_START + 8 +: 4];
        end else if (ok_short) begin
            result.first_value  = window[SHORT_START + 4 +: 4];
        end
    end

endmodule

[design/response_frame_sync_core.sv]
// ----------------------------------------------------------------------------
// Response frame sync core
// A result appears in the output register in the cycle after its transaction is
// accepted. Throughput: one transaction per cycle unless m_ready stalls the output,
// set by the byte cell shift and the checksum adders ahead of the output register.
// Reset (aresetn low, synchronous): window, counters and output valid clear,
// expected_command returns to 3 and timeout_ms to 100.
// ----------------------------------------------------------------------------
`include "response_frame_sync_core_macros.svh"

module response_frame_sync_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_first_value,
    output logic [31:0] m_second_value
);
    import rfs_pkg::*;

    logic [7:0]  cmd_reg;
    logic [15:0] timeout_reg;
    logic        waiting_reg, waiting_next;
    logic [3:0]  seen_reg, seen_next, seen_inc;
    logic [15:0] elapsed_reg, elapsed_next, elapsed_inc;
    logic        m_valid_reg, m_valid_next;
    logic [2:0]  status_reg, status_next;
    logic [31:0] first_reg, first_next;
    logic [31:0] second_reg, second_next;

    logic        s_fire;
    logic        cell_shift;
    logic        cell_clear;
    logic [3:0]  flen;
    window_t     window;
    window_t     window_shifted;
    match_t      match;
    logic        m_status_reg_is_idle;

    assign s_ready    = !m_valid_reg || m_ready;
    assign s_fire     = s_valid && s_ready;
    assign cell_shift = s_fire && (s_mode == MODE_BYTE) && waiting_reg;
    assign cell_clear = s_fire && (s_mode == MODE_START);
    assign flen       = frame_len(cmd_reg);

    // The newest byte enters at the top cell; every other cell takes its upper neighbor.
    always_comb begin
        for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
            window_shifted[i] = window[i+1];
        end
        window_shifted[WINDOW_DEPTH-1] = s_rx_byte;
    end

    for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
        rfs_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .clear   (cell_clear),
            .shift   (cell_shift),
            .din     (window_shifted[g]),
            .q       (window[g])
        );
    end

    assign seen_inc    = (seen_reg == SEEN_MAX) ? seen_reg : seen_reg + 4'd1;
    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;

    rfs_matcher u_matcher (
        .window    (window_shifted),
        .command   (cmd_reg),
        .frame_len (flen),
        .count     (seen_inc),
        .result    (match)
    );

    always_comb begin
        waiting_next = waiting_reg;
        seen_next    = seen_reg;
        elapsed_next = elapsed_reg;
        status_next  = waiting_reg ? ST_SEARCH : ST_IDLE;
        first_next   = 32'h0;
        second_next  = 32'h0;
        if (s_mode == MODE_START) begin
            waiting_next = 1'b1;
            seen_next    = 4'd0;
            elapsed_next = 16'd0;
            status_next  = ST_SEARCH;
        end else if (s_mode == MODE_BYTE && waiting_reg) begin
            seen_next = seen_inc;
            if (flen == LEN_NONE) begin
                status_next  = ST_RAW;
                first_next   = {24'h0, s_rx_byte};
                waiting_next = 1'b0;
            end else if (match.hit) begin
                status_next  = ST_MATCH;
                first_next   = match.first_value;
                second_next  = match.second_value;
                waiting_next = 1'b0;
            end
        end else if (s_mode == MODE_TICK && waiting_reg) begin
            elapsed_next = elapsed_inc;
            if (elapsed_inc >= timeout_reg) begin
                status_next  = ST_TIMEOUT;
                waiting_next = 1'b0;
            end
        end
    end

    assign m_valid_next = s_fire || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg     <= 8'd3;
            timeout_reg <= 16'd100;
            waiting_reg <= 1'b0;
            seen_reg    <= 4'd0;
            elapsed_reg <= 16'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we && cfg_addr == REG_EXPECTED_COMMAND) begin
                cmd_reg <= cfg_wdata[7:0];
            end
            if (cfg_we && cfg_addr == REG_TIMEOUT_MS) begin
                timeout_reg <= cfg_wdata;
            end
            if (s_fire) begin
                waiting_reg <= waiting_next;
                seen_reg    <= seen_next;
                elapsed_reg <= elapsed_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            status_reg <= status_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_first_value  = first_reg;
    assign m_second_value = second_reg;

    assign m_status_reg_is_idle = (status_reg == ST_IDLE) && (first_reg == 32'h0);

    // A start transaction opens the search with a cleared count and timer.
    `RFS_ASSERT_NEXT(a_start_opens, s_fire && s_mode == MODE_START,
        waiting_reg && seen_reg == 4'd0 && elapsed_reg == 16'd0)
    // Anything but a start while idle is reported as ignored.
    `RFS_ASSERT_NEXT(a_idle_ignored, s_fire && !waiting_reg && s_mode != MODE_START,
        m_status_reg_is_idle)
    // A closing status always leaves the block idle.
    `RFS_ASSERT_SAME(a_close_idles,
        m_valid_reg && $past(s_fire) &&
        (status_reg == ST_MATCH || status_reg == ST_RAW || status_reg == ST_TIMEOUT),
        !waiting_reg)
    // The window never moves while idle.
    `RFS_ASSERT_SAME(a_no_shift_idle, cell_shift, waiting_reg && !cell_clear)

endmodule
